@@ design/kts_pkg.sv @@
// Shared types, constants, translation and pointer functions for the scancode queue.
package kts_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = (PTR_W > 6) ? PTR_W : 6;
    localparam int FREE_W      = 6;

    typedef enum logic [1:0] {
        OP_KEY = 2'd0,
        OP_RAW = 2'd1,
        OP_POP = 2'd2,
        OP_CLR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOMAP = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_NOMAP = 2'd0,
        CMD_PUT   = 2'd1,
        CMD_POP   = 2'd2,
        CMD_CLR   = 2'd3
    } cmd_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_PUT2 = 2'd1,
        BK_POP  = 2'd2
    } back_state_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        two_bytes;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
    } cmd_t;

    localparam logic [7:0]  PREFIX_EXT = 8'hE0;
    localparam logic [7:0]  SC_SPACE   = 8'h39;
    localparam logic [7:0]  SC_ENTER   = 8'h1C;
    localparam logic [7:0]  SC_UP      = 8'h48;
    localparam logic [7:0]  SC_DOWN    = 8'h50;
    localparam logic [7:0]  SC_RIGHT   = 8'h4D;
    localparam logic [7:0]  SC_LEFT    = 8'h4B;

    localparam logic [15:0] FW_UP      = 16'h0001;
    localparam logic [15:0] FW_DOWN    = 16'h0002;
    localparam logic [15:0] FW_RIGHT   = 16'h0003;
    localparam logic [15:0] FW_LEFT    = 16'h0004;

    localparam logic [15:0] UC_LOWER_A = 16'h0061;
    localparam logic [15:0] UC_LOWER_Z = 16'h007A;
    localparam logic [15:0] UC_UPPER_A = 16'h0041;
    localparam logic [15:0] UC_UPPER_Z = 16'h005A;
    localparam logic [15:0] UC_SPACE   = 16'h0020;
    localparam logic [15:0] UC_CR      = 16'h000D;

    // Set 1 make codes for the letters a to z
    function automatic logic [7:0] letter_code(input logic [4:0] idx);
        logic [7:0] code;
        case (idx)
            5'd0:    code = 8'h1E;
            5'd1:    code = 8'h30;
            5'd2:    code = 8'h2E;
            5'd3:    code = 8'h20;
            5'd4:    code = 8'h12;
            5'd5:    code = 8'h21;
            5'd6:    code = 8'h22;
            5'd7:    code = 8'h23;
            5'd8:    code = 8'h17;
            5'd9:    code = 8'h24;
            5'd10:   code = 8'h25;
            5'd11:   code = 8'h26;
            5'd12:   code = 8'h32;
            5'd13:   code = 8'h31;
            5'd14:   code = 8'h18;
            5'd15:   code = 8'h19;
            5'd16:   code = 8'h10;
            5'd17:   code = 8'h13;
            5'd18:   code = 8'h1F;
            5'd19:   code = 8'h14;
            5'd20:   code = 8'h16;
            5'd21:   code = 8'h2F;
            5'd22:   code = 8'h11;
            5'd23:   code = 8'h2D;
            5'd24:   code = 8'h15;
            5'd25:   code = 8'h2C;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

    // Ring pointer step with wrap at the queue depth
    function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            q = '0;
        else
            q = p + 1'b1;
        return q;
    endfunction

endpackage

@@ design/keystroke_to_set1_scancode_fifo.sv @@
// Top level of the keystroke to PS/2 Set 1 scancode queue.
// Each input request carries one operation in s_axis_tuser: translate a
// keystroke into Set 1 make codes and queue them, queue one raw byte, pop
// the oldest byte, or reset the queue pointers. Every request gives exactly
// one result, in request order, with a status, the popped byte (zero unless
// a pop succeeded) and the free slot count after the operation. The ring
// holds QUEUE_DEPTH-1 bytes; an arrow key's two-byte sequence goes in whole
// or not at all. Requests are classified on entry and wait in a two-entry
// command queue, so the input keeps taking requests while a result waits on
// the output register. The back end runs one command at a time against a
// single-port ring RAM: a one-byte push, a rejected request or a pointer
// reset is done from the idle state, while an extended key (two ring writes)
// and a successful pop (ring read with registered data) also pass through
// BK_PUT2 or BK_POP, and no new command is taken until the back end is idle
// again. The ring contents are not cleared at reset; only bytes that have been queued are ever popped.
module keystroke_to_set1_scancode_fifo (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // unicode_char[15:0], firmware_scan_code[31:16],
                                       // raw_byte[39:32]
    input  logic [1:0]  s_axis_tuser,  // op[1:0]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // data_byte[7:0], free_slots[13:8], zero[15:14]
    output logic [1:0]  m_axis_tuser   // status[1:0]
);
    import kts_pkg::*;

    cmd_t              front_cmd;
    cmd_t              back_cmd;
    logic              back_valid;
    logic              back_ready;
    status_t           res_status;
    logic [7:0]        res_data;
    logic [FREE_W-1:0] res_free;

    // Classify the request and translate keystrokes
    kts_front u_front (
        .op                 (op_t'(s_axis_tuser)),
        .unicode_char       (s_axis_tdata[15:0]),
        .firmware_scan_code (s_axis_tdata[31:16]),
        .raw_byte           (s_axis_tdata[39:32]),
        .cmd                (front_cmd)
    );

    // Decouple intake from execution
    kts_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (front_cmd),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_cmd   (back_cmd)
    );

    // Execute against the ring and hold the result until taken
    kts_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (back_valid),
        .cmd_ready  (back_ready),
        .cmd        (back_cmd),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res_status (res_status),
        .res_data   (res_data),
        .res_free   (res_free)
    );

    assign m_axis_tdata = {2'b00, res_free, res_data};
    assign m_axis_tuser = res_status;

    // A byte comes out only with a successful pop
    a_data_zero_unless_ok: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata[7:0] == 8'h00)
    ) else $error("non-zero data byte on a result that is not ok");

    // An empty pop reports a completely free queue
    a_empty_all_free: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_EMPTY))
            |-> (m_axis_tdata[13:8] == FREE_W'(QUEUE_DEPTH - 1))
    ) else $error("empty status with bytes still counted in the queue");

    // The back end never takes a command while the result register is blocked
    a_no_take_when_blocked: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !back_ready
    ) else $error("command taken while the previous result is stalled");

endmodule

@@ design/kts_ram.sv @@
// Generic single-port RAM with registered read data.
module kts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[addr] <= wdata;
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/kts_front.sv @@
// Front end: classify one request and translate keystrokes to Set 1 codes.
module kts_front (
    input  kts_pkg::op_t  op,
    input  logic [15:0]   unicode_char,
    input  logic [15:0]   firmware_scan_code,
    input  logic [7:0]    raw_byte,
    output kts_pkg::cmd_t cmd
);
    import kts_pkg::*;

    logic [15:0] lower_off;
    logic [15:0] upper_off;

    assign lower_off = unicode_char - UC_LOWER_A;
    assign upper_off = unicode_char - UC_UPPER_A;

    always_comb
    begin
        cmd.kind      = CMD_NOMAP;
        cmd.two_bytes = 1'b0;
        cmd.byte0     = 8'h00;
        cmd.byte1     = 8'h00;
        case (op)
            OP_KEY:
            begin
                // letters first, then space and return, then the arrow keys
                if (unicode_char inside {[UC_LOWER_A:UC_LOWER_Z]}) begin
                    cmd.kind  = CMD_PUT;
                    cmd.byte0 = letter_code(lower_off[4:0]);
                end else if (unicode_char inside {[UC_UPPER_A:UC_UPPER_Z]}) begin
                    cmd.kind  = CMD_PUT;
                    cmd.byte0 = letter_code(upper_off[4:0]);
                end else if (unicode_char == UC_SPACE) begin
                    cmd.kind  = CMD_PUT;
                    cmd.byte0 = SC_SPACE;
                end else if (unicode_char == UC_CR) begin
                    cmd.kind  = CMD_PUT;
                    cmd.byte0 = SC_ENTER;
                end else begin
                    cmd.byte0 = PREFIX_EXT;
                    case (firmware_scan_code)
                        FW_UP:    cmd.byte1 = SC_UP;
                        FW_DOWN:  cmd.byte1 = SC_DOWN;
                        FW_RIGHT: cmd.byte1 = SC_RIGHT;
                        FW_LEFT:  cmd.byte1 = SC_LEFT;
                        default:  cmd.byte1 = 8'h00;
                    endcase
                    if (firmware_scan_code inside {FW_UP, FW_DOWN, FW_RIGHT, FW_LEFT}) begin
                        cmd.kind      = CMD_PUT;
                        cmd.two_bytes = 1'b1;
                    end
                end
            end
            OP_RAW:
            begin
                cmd.kind  = CMD_PUT;
                cmd.byte0 = raw_byte;
            end
            OP_POP:  cmd.kind = CMD_POP;
            OP_CLR:  cmd.kind = CMD_CLR;
            default: cmd.kind = CMD_NOMAP;
        endcase
    end

endmodule

@@ design/kts_cmdq.sv @@
// Two-entry command queue between the front end and the back end.
module kts_cmdq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  kts_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output kts_pkg::cmd_t out_cmd
);
    import kts_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_sel_reg;
    logic       wr_sel_next;
    logic       rd_sel_reg;
    logic       rd_sel_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_cmd   = slot_reg[rd_sel_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_sel_next = push ? ~wr_sel_reg : wr_sel_reg;
        rd_sel_next = pop ? ~rd_sel_reg : rd_sel_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_sel_reg <= 1'b0;
            rd_sel_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_sel_reg <= wr_sel_next;
            rd_sel_reg <= rd_sel_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_sel_reg] <= in_cmd;
    end

endmodule

@@ design/kts_back.sv @@
// Back end: run commands against the scancode ring and register each result.
module kts_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  kts_pkg::cmd_t               cmd,
    output logic                        res_valid,
    input  logic                        res_ready,
    output kts_pkg::status_t            res_status,
    output logic [7:0]                  res_data,
    output logic [kts_pkg::FREE_W-1:0]  res_free
);
    import kts_pkg::*;

    back_state_t      state_reg;
    back_state_t      state_next;
    logic [PTR_W-1:0] wp_reg;
    logic [PTR_W-1:0] wp_next;
    logic [PTR_W-1:0] rp_reg;
    logic [PTR_W-1:0] rp_next;
    logic [PTR_W-1:0] used_reg;
    logic [PTR_W-1:0] used_next;
    logic [7:0]       b1_reg;
    logic [7:0]       b1_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    status_t          out_status_reg;
    status_t          out_status_next;
    logic [7:0]       out_data_reg;
    logic [7:0]       out_data_next;
    logic [FREE_W-1:0] out_free_reg;
    logic [FREE_W-1:0] out_free_next;

    logic             ram_we;
    logic [PTR_W-1:0] ram_addr;
    logic [7:0]       ram_wdata;
    logic [7:0]       ram_rdata;

    logic [CNT_W-1:0] free_now;
    logic [CNT_W-1:0] need;
    logic [CNT_W-1:0] free_res;
    logic             take;

    kts_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign free_now  = CNT_W'(QUEUE_DEPTH - 1) - CNT_W'(used_reg);
    assign need      = cmd.two_bytes ? CNT_W'(2) : CNT_W'(1);
    assign cmd_ready = (state_reg == BK_IDLE) && (!out_valid_reg || res_ready);
    assign take      = cmd_valid && cmd_ready;

    always_comb
    begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        used_next       = used_reg;
        b1_next         = b1_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_free_next   = out_free_reg;
        ram_we          = 1'b0;
        ram_addr        = wp_reg;
        ram_wdata       = cmd.byte0;
        free_res        = free_now;

        case (state_reg)
            BK_IDLE:
            begin
                if (take) begin
                    out_valid_next = 1'b1;
                    out_data_next  = 8'h00;
                    out_status_next = ST_OK;
                    case (cmd.kind)
                        CMD_PUT:
                        begin
                            if (free_now < need) begin
                                out_status_next = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                wp_next   = ptr_adv(wp_reg);
                                used_next = used_reg + 1'b1;
                                free_res  = free_now - need;
                                b1_next   = cmd.byte1;
                                if (cmd.two_bytes)
                                    state_next = BK_PUT2;
                            end
                        end
                        CMD_POP:
                        begin
                            if (used_reg == '0) begin
                                out_status_next = ST_EMPTY;
                            end else begin
                                // hold the result until the ring read returns
                                out_valid_next = 1'b0;
                                ram_addr       = rp_reg;
                                state_next     = BK_POP;
                            end
                        end
                        CMD_CLR:
                        begin
                            wp_next   = '0;
                            rp_next   = '0;
                            used_next = '0;
                            free_res  = CNT_W'(QUEUE_DEPTH - 1);
                        end
                        default: out_status_next = ST_NOMAP;
                    endcase
                    out_free_next = free_res[FREE_W-1:0];
                end
            end
            BK_PUT2:
            begin
                ram_we     = 1'b1;
                ram_wdata  = b1_reg;
                wp_next    = ptr_adv(wp_reg);
                used_next  = used_reg + 1'b1;
                state_next = BK_IDLE;
            end
            BK_POP:
            begin
                ram_addr        = rp_reg;
                free_res        = free_now + 1'b1;
                out_valid_next  = 1'b1;
                out_status_next = ST_OK;
                out_data_next   = ram_rdata;
                out_free_next   = free_res[FREE_W-1:0];
                rp_next         = ptr_adv(rp_reg);
                used_next       = used_reg - 1'b1;
                state_next      = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= BK_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_reg         <= b1_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_free_reg   <= out_free_next;
    end

    assign res_valid  = out_valid_reg;
    assign res_status = out_status_reg;
    assign res_data   = out_data_reg;
    assign res_free   = out_free_reg;

endmodule
